/* design/servo_feedback_frame_decoder_macros.svh */
// Assertion helpers for the servo feedback frame decoder.
`ifndef SERVO_FEEDBACK_FRAME_DECODER_MACROS_SVH
`define SERVO_FEEDBACK_FRAME_DECODER_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define SFD_ASSERT_NOW(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sfd: same-cycle check failed");

// Check that cons holds in the cycle after ante.
`define SFD_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sfd: next-cycle check failed");

`endif

/* design/sfd_pkg.sv */
`default_nettype none

package sfd_pkg;

  // Header bytes of a feedback frame
  localparam logic [7:0] HDR0 = 8'h55;
  localparam logic [7:0] HDR1 = 8'hAA;
  localparam logic [7:0] HDR2 = 8'h02;

  // Configuration register indexes
  localparam logic [1:0] REG_JOINTS_IN_USE = 2'd0;
  localparam logic [1:0] REG_INVERT_MASK   = 2'd1;
  localparam logic [1:0] REG_WIDE_MASK     = 2'd2;

  // Pulse to angle line: narrow is (p - 2000) / 2200, wide is (3p - 4460) / 6640, times pi
  localparam logic [19:0] OFF_NARROW = 20'd2000;
  localparam logic [19:0] OFF_WIDE   = 20'd4460;
  localparam logic [12:0] DEN_NARROW = 13'd2200;
  localparam logic [12:0] DEN_WIDE   = 13'd6640;

  // Range divide as a reciprocal multiply: 2200 is 8 * 275 and 6640 is 16 * 415, and
  // for n below 2^26 floor(n / 275) and floor(n / 415) are (n * REC) >> 35 exactly
  localparam logic [26:0] REC_NARROW = 27'd124944504;
  localparam logic [26:0] REC_WIDE   = 27'd82794551;

  // pi scaled by 2^32, rounded
  localparam logic [33:0] PI_Q32 = 34'd13493037705;

  // Angle unit request and result
  typedef struct packed {
    logic start;
    logic inv;
    logic wide;
  } ang_req_t;

  typedef struct packed {
    logic               done;
    logic signed [15:0] angle;
  } ang_res_t;

endpackage

`default_nettype wire

/* design/sfd_ram.sv */
`default_nettype none

module sfd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 6
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* design/sfd_angle.sv */
`default_nettype none

module sfd_angle
  import sfd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire ang_req_t    req,
  input  wire logic [15:0] pulse,
  output ang_res_t         res
);

  localparam logic [2:0] A_IDLE  = 3'd0;
  localparam logic [2:0] A_MUL   = 3'd1;
  localparam logic [2:0] A_LOAD  = 3'd2;
  localparam logic [2:0] A_RECIP = 3'd3;
  localparam logic [2:0] A_DONE  = 3'd4;

  logic [2:0]  state_r, state_nxt;
  logic        zero_r, neg_r, big_r, wide_r;
  logic [14:0] mag_r;
  logic [29:0] prod_r;
  logic [25:0] rem_r;
  logic [17:0] q_r;

  logic [19:0] pe, nl, ns, mag;
  logic        neg;
  logic [12:0] den;
  logic [29:0] sum;
  logic [33:0] mul_a;
  logic [25:0] mul_b;
  logic [52:0] mul_p;
  logic [15:0] angle;

  // Signed offset from the range centre, mirrored if asked
  always_comb begin
    pe  = {4'd0, pulse};
    nl  = req.wide ? (pe + (pe << 1)) - OFF_WIDE : pe - OFF_NARROW;
    ns  = req.inv ? (~nl + 20'd1) : nl;
    neg = ns[19];
    mag = neg ? (~ns + 20'd1) : ns;
  end

  // Shared multiplier: pi on the first pass, the range reciprocal on the second
  always_comb begin
    if (state_r == A_RECIP) begin
      mul_a = wide_r ? {7'd0, REC_WIDE} : {7'd0, REC_NARROW};
      mul_b = rem_r;
    end else begin
      mul_a = PI_Q32;
      mul_b = {11'd0, mag_r};
    end
  end

  assign mul_p = 53'(mul_a) * 53'(mul_b);

  // Half the divisor as rounding term; the bits below 2^19 never carry into it
  assign den = wide_r ? DEN_WIDE : DEN_NARROW;
  assign sum = prod_r + 30'(den);

  // Sequence: capture, multiply by pi, add rounding term, reciprocal multiply
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      A_IDLE:  if (req.start) state_nxt = A_MUL;
      A_MUL:   state_nxt = A_LOAD;
      A_LOAD:  state_nxt = A_RECIP;
      A_RECIP: state_nxt = A_DONE;
      A_DONE:  state_nxt = A_IDLE;
      default: state_nxt = A_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= A_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      A_IDLE: begin
        if (req.start) begin
          zero_r <= pulse == 16'd0;
          neg_r  <= neg;
          big_r  <= |mag[19:15];
          mag_r  <= mag[14:0];
          wide_r <= req.wide;
        end
      end
      A_MUL: begin
        prod_r <= mul_p[48:19];
      end
      A_LOAD: begin
        // drop the power-of-two part of the divisor
        rem_r <= wide_r ? {1'b0, sum[29:5]} : sum[29:4];
      end
      A_RECIP: begin
        q_r <= mul_p[52:35];
      end
      default: begin
      end
    endcase
  end

  // Sign and saturate the quotient
  always_comb begin
    if (zero_r) begin
      angle = 16'h0000;
    end else if (neg_r) begin
      angle = (big_r || q_r > 18'd32768) ? 16'h8000 : 16'(~q_r + 18'd1);
    end else begin
      angle = (big_r || q_r > 18'd32767) ? 16'h7FFF : q_r[15:0];
    end
  end

  assign res.done  = state_r == A_DONE;
  assign res.angle = signed'(angle);

endmodule

`default_nettype wire

/* design/servo_feedback_frame_decoder.sv */
// Servo feedback frame decoder. Bytes arrive on the in_ channel and are taken one
// per cycle while the block is hunting a 55 AA 02 header or collecting the
// 2*JOINT_COUNT payload bytes (big-endian pulse widths, kept in a small RAM).
// The last byte of a frame starts decoding unless the first three pulses are all
// zero or no joint is in use; the block then stalls its input while one angle per
// joint in use is produced in joint order, each in radians Q12, saturated,
// last_joint set on the final one. Each angle passes through RAM read, start,
// multiply by pi, rounding add, reciprocal multiply for the range divide,
// hand-back and output load, with one shared multiplier; out_stall can hold the
// output register in the last step, which keeps the input stalled longer.
// Configure only while idle.
`default_nettype none

`include "servo_feedback_frame_decoder_macros.svh"

module servo_feedback_frame_decoder
  import sfd_pkg::*;
#(
  parameter int JOINT_COUNT = 6
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [7:0]         in_rx_byte,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [2:0]              out_joint_index,
  output logic signed [15:0]      out_angle_q12,
  output logic                    out_last_joint,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [5:0]         cfg_wdata
);

  localparam int FRAME_LEN = 3 + 2 * JOINT_COUNT;
  localparam int PW        = $clog2(FRAME_LEN);
  localparam int JW        = JOINT_COUNT > 1 ? $clog2(JOINT_COUNT) : 1;
  localparam int CW        = (JW > 3 ? JW : 3) + 1;
  localparam int CHK_BYTES = 2 * (JOINT_COUNT < 3 ? JOINT_COUNT : 3);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RD    = 3'd1;
  localparam logic [2:0] S_START = 3'd2;
  localparam logic [2:0] S_CALC  = 3'd3;
  localparam logic [2:0] S_PUSH  = 3'd4;

  logic [2:0]  joints_r;
  logic [5:0]  inv_mask_r, wide_mask_r;
  logic [2:0]  state_r;
  logic [PW-1:0] pos_r;
  logic [7:0]  hi_r;
  logic        any_nz_r;
  logic [2:0]  used_r;
  logic [JW-1:0] jdx_r;
  logic signed [15:0] res_angle_r;
  logic        out_valid_r;
  logic [2:0]  out_joint_r;
  logic signed [15:0] out_angle_r;
  logic        out_last_r;

  logic        in_acc, out_acc, out_free;
  logic [7:0]  want;
  logic [PW-1:0] idx;
  logic [JW-1:0] waddr;
  logic        we;
  logic        chk_hit, any_now, frame_end;
  logic [2:0]  used_now;
  logic [CW-1:0] jx;
  logic        last;
  logic [7:0]  inv_ext, wide_ext;
  logic [15:0] rdata;
  ang_req_t    ang_req;
  ang_res_t    ang_res;

  assign in_stall = state_r != S_IDLE;
  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid_r && !out_stall;
  assign out_free = !out_valid_r || !out_stall;

  // Byte parsing helpers
  always_comb begin
    unique case (pos_r)
      PW'(0):  want = HDR0;
      PW'(1):  want = HDR1;
      default: want = HDR2;
    endcase
    idx       = pos_r - PW'(3);
    waddr     = JW'(idx >> 1);
    we        = in_acc && pos_r >= PW'(3) && idx[0];
    chk_hit   = idx < PW'(CHK_BYTES) && in_rx_byte != 8'd0;
    any_now   = any_nz_r || chk_hit;
    frame_end = pos_r == PW'(FRAME_LEN - 1);
    used_now  = (32'(joints_r) > JOINT_COUNT) ? 3'(JOINT_COUNT) : joints_r;
  end

  // Per-joint selection
  always_comb begin
    jx       = CW'(jdx_r);
    last     = (jx + CW'(1)) == CW'(used_r);
    inv_ext  = {2'b00, inv_mask_r};
    wide_ext = {2'b00, wide_mask_r};
    ang_req.start = state_r == S_START;
    ang_req.inv   = jx < CW'(6) && inv_ext[jx[2:0]];
    ang_req.wide  = jx < CW'(6) && wide_ext[jx[2:0]];
  end

  // Pulse store, one word per joint
  sfd_ram #(
    .WIDTH(16),
    .DEPTH(JOINT_COUNT)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata({hi_r, in_rx_byte}),
    .raddr(jdx_r),
    .rdata(rdata)
  );

  sfd_angle u_angle (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (ang_req),
    .pulse(rdata),
    .res  (ang_res)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      joints_r    <= 3'd6;
      inv_mask_r  <= 6'd14;
      wide_mask_r <= 6'd16;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_JOINTS_IN_USE: joints_r    <= cfg_wdata[2:0];
        REG_INVERT_MASK:   inv_mask_r  <= cfg_wdata;
        REG_WIDE_MASK:     wide_mask_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Hunt header, collect payload, run the decode sequence
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      pos_r    <= '0;
      any_nz_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (pos_r < PW'(3)) begin
              if (in_rx_byte == want) begin
                pos_r <= pos_r + PW'(1);
              end else begin
                pos_r <= (in_rx_byte == HDR0) ? PW'(1) : PW'(0);
              end
              any_nz_r <= 1'b0;
            end else if (frame_end) begin
              pos_r <= '0;
              if (any_now && used_now != 3'd0) begin
                state_r <= S_RD;
              end
            end else begin
              pos_r    <= pos_r + PW'(1);
              any_nz_r <= any_now;
            end
          end
        end
        S_RD:    state_r <= S_START;
        S_START: state_r <= S_CALC;
        S_CALC:  if (ang_res.done) state_r <= S_PUSH;
        S_PUSH: begin
          if (out_free) begin
            state_r <= last ? S_IDLE : S_RD;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Payload-side registers
  always_ff @(posedge clk) begin
    if (in_acc && pos_r >= PW'(3) && !idx[0]) begin
      hi_r <= in_rx_byte;
    end
    if (in_acc && frame_end) begin
      used_r <= used_now;
      jdx_r  <= '0;
    end else if (state_r == S_PUSH && out_free && !last) begin
      jdx_r <= jdx_r + JW'(1);
    end
    if (state_r == S_CALC && ang_res.done) begin
      res_angle_r <= ang_res.angle;
    end
  end

  // Output register: load a beat when the slot is free, drop it once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_PUSH && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_acc) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_PUSH && out_free) begin
      out_joint_r <= jx[2:0];
      out_angle_r <= res_angle_r;
      out_last_r  <= last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_joint_index = out_joint_r;
  assign out_angle_q12   = out_angle_r;
  assign out_last_joint  = out_last_r;

  // Checks
  `SFD_ASSERT_NOW(a_joint_in_range, clk, rst_n, out_valid_r, out_joint_r < used_r)
  `SFD_ASSERT_NEXT(a_busy_after_mid_beat, clk, rst_n, out_acc && !out_last_r, state_r != S_IDLE || out_valid_r)
  `SFD_ASSERT_NOW(a_done_when_waiting, clk, rst_n, ang_res.done, state_r == S_CALC)

endmodule

`default_nettype wire

/* tb/servo_angle_checker.sv */
module servo_angle_checker
  import sfd_pkg::*;
#(
  parameter int JOINT_COUNT = 6
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [7:0]         in_rx_byte,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [2:0]         out_joint_index,
  input  logic signed [15:0] out_angle_q12,
  input  logic               out_last_joint,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [5:0]         cfg_wdata,
  output int                 errors,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PAYLOAD_LEN = 2 * JOINT_COUNT;
  localparam int FRAME_LEN   = 3 + PAYLOAD_LEN;
  localparam int ZERO_CHECK  = (JOINT_COUNT < 3) ? JOINT_COUNT : 3;
  localparam int MAX_LINES   = 100;

  typedef struct packed {
    logic [2:0]         joint;
    logic signed [15:0] angle;
    logic               last;
  } angle_beat_t;

  angle_beat_t expected_angles[$];

  // Shadow of the configuration and the frame parser
  logic [2:0] joints_in_use;
  logic [5:0] invert_mask;
  logic [5:0] wide_mask;
  int         frame_pos;
  logic [7:0] payload [PAYLOAD_LEN];

  task automatic report_mismatch(input string what);
    if (errors < MAX_LINES)
      $display("%0t ns mismatch: %s", $time, what);
    errors++;
  endtask

  // Map a pulse width to radians in Q12, rounded half away from zero, saturated
  function automatic logic signed [15:0] pulse_to_angle(input logic [15:0] pulse,
                                                        input logic mirror,
                                                        input logic wide);
    longint          num;
    longint unsigned den;
    longint unsigned mag;
    longint unsigned q;
    logic            neg;
    if (pulse == 16'd0)
      return 16'sd0;
    if (wide) begin
      num = 3 * longint'(pulse) - longint'(OFF_WIDE);
      den = longint'(DEN_WIDE);
    end else begin
      num = longint'(pulse) - longint'(OFF_NARROW);
      den = longint'(DEN_NARROW);
    end
    if (mirror)
      num = -num;
    neg = num < 0;
    mag = neg ? longint'(-num) : num;
    den = den << 20;
    q = (mag * PI_Q32 + den / 2) / den;
    if (neg)
      return (q > 64'd32768) ? 16'sh8000 : 16'(64'd0 - q);
    return (q > 64'd32767) ? 16'sh7FFF : 16'(q);
  endfunction

  // Advance the parser by one received byte and queue the angles of a finished frame
  function automatic void take_byte(input logic [7:0] b);
    logic [7:0]  want;
    logic        any_pulse;
    int          used;
    logic [15:0] pulse;
    logic        mirror;
    logic        wide;
    angle_beat_t beat;
    if (frame_pos < 3) begin
      want = (frame_pos == 0) ? HDR0 : (frame_pos == 1) ? HDR1 : HDR2;
      if (b == want)
        frame_pos++;
      else
        frame_pos = (b == HDR0) ? 1 : 0;
      return;
    end
    payload[frame_pos - 3] = b;
    frame_pos++;
    if (frame_pos < FRAME_LEN)
      return;
    frame_pos = 0;

    // drop frames whose leading pulses are all zero
    any_pulse = 1'b0;
    for (int j = 0; j < ZERO_CHECK; j++)
      if (payload[2 * j] != 8'd0 || payload[2 * j + 1] != 8'd0)
        any_pulse = 1'b1;
    if (!any_pulse)
      return;

    used = (int'(joints_in_use) > JOINT_COUNT) ? JOINT_COUNT : int'(joints_in_use);
    for (int j = 0; j < used; j++) begin
      mirror = (j < 6) ? invert_mask[j] : 1'b0;
      wide   = (j < 6) ? wide_mask[j] : 1'b0;
      pulse  = {payload[2 * j], payload[2 * j + 1]};
      beat.joint = 3'(j);
      beat.angle = pulse_to_angle(pulse, mirror, wide);
      beat.last  = (j + 1 == used);
      expected_angles.push_back(beat);
    end
  endfunction

  always @(posedge clk) begin
    angle_beat_t want;
    if (!rst_n) begin
      joints_in_use = 3'd6;
      invert_mask   = 6'd14;
      wide_mask     = 6'd16;
      frame_pos     = 0;
      foreach (payload[i])
        payload[i] = 8'h00;
      expected_angles.delete();
    end else begin
      // track register writes
      if (cfg_we) begin
        case (cfg_index)
          REG_JOINTS_IN_USE: joints_in_use = cfg_wdata[2:0];
          REG_INVERT_MASK:   invert_mask   = cfg_wdata;
          REG_WIDE_MASK:     wide_mask     = cfg_wdata;
          default: ;
        endcase
      end

      // compare each angle beat with the oldest expectation
      if (out_valid && !out_stall) begin
        if (expected_angles.size() == 0) begin
          report_mismatch($sformatf("unexpected angle beat joint %0d angle %0d last %0b",
                                    out_joint_index, out_angle_q12, out_last_joint));
        end else begin
          want = expected_angles.pop_front();
          if (out_joint_index !== want.joint)
            report_mismatch($sformatf("joint_index %0d, want %0d",
                                      out_joint_index, want.joint));
          if (out_angle_q12 !== want.angle)
            report_mismatch($sformatf("joint %0d angle_q12 %0d, want %0d",
                                      want.joint, out_angle_q12, want.angle));
          if (out_last_joint !== want.last)
            report_mismatch($sformatf("joint %0d last_joint %0b, want %0b",
                                      want.joint, out_last_joint, want.last));
        end
      end

      // feed each accepted byte to the parser
      if (in_valid && !in_stall)
        take_byte(in_rx_byte);
    end
    pending = expected_angles.size();
  end

endmodule

/* tb/servo_feedback_frame_decoder_tb.sv */
module servo_feedback_frame_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sfd_pkg::*;

  localparam int JOINTS      = 6;
  localparam int IDLE_PCT    = 21;
  localparam int SETTLE      = 200;
  localparam int STALL_LIMIT = 4000;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic [7:0]               in_rx_byte;
  logic                     out_valid;
  logic                     out_stall;
  logic [2:0]               out_joint_index;
  logic signed [15:0]       out_angle_q12;
  logic                     out_last_joint;
  logic                     cfg_we;
  logic [1:0]               cfg_index;
  logic [5:0]               cfg_wdata;

  logic calm;
  int   errors;
  int   pending;
  int   quiet_cycles;
  int   bytes_sent;

  servo_feedback_frame_decoder #(.JOINT_COUNT(JOINTS)) u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_joint_index (out_joint_index),
    .out_angle_q12   (out_angle_q12),
    .out_last_joint  (out_last_joint),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  servo_angle_checker #(.JOINT_COUNT(JOINTS)) u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_joint_index (out_joint_index),
    .out_angle_q12   (out_angle_q12),
    .out_last_joint  (out_last_joint),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .errors          (errors),
    .pending         (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Stall the angle channel at random, except in the calm stretch
  always @(posedge clk)
    out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);

  // End the run if no beat moves for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one byte, after a random gap outside the calm stretch, and hold it until taken
  task automatic send_byte(input logic [7:0] b);
    if (!calm) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall !== 1'b0)
      @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [JOINTS-1:0][15:0] pulses);
    send_byte(HDR0);
    send_byte(HDR1);
    send_byte(HDR2);
    for (int j = 0; j < JOINTS; j++) begin
      send_byte(pulses[j][15:8]);
      send_byte(pulses[j][7:0]);
    end
  endtask

  // Half in-range widths, the rest zeros, all-ones, tiny values and full 16-bit noise
  function automatic logic [15:0] random_pulse();
    case ($urandom_range(9))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(3, 1));
      3, 4, 5: return 16'($urandom_range(3100, 900));
      6, 7:    return 16'($urandom_range(3700, 380));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [JOINTS-1:0][15:0] random_frame(input logic drop);
    logic [JOINTS-1:0][15:0] pulses;
    for (int j = 0; j < JOINTS; j++)
      pulses[j] = (drop && j < 3) ? 16'd0 : random_pulse();
    return pulses;
  endfunction

  task automatic random_traffic(input int budget);
    int start_count;
    int pick;
    start_count = bytes_sent;
    while (bytes_sent - start_count < budget) begin
      pick = $urandom_range(99);
      if (pick < 65) begin
        send_frame(random_frame(1'b0));
      end else if (pick < 75) begin
        send_frame(random_frame(1'b1));
      end else if (pick < 87) begin
        // partial header cut short by an arbitrary byte
        send_byte(HDR0);
        if ($urandom_range(1))
          send_byte(HDR1);
        send_byte(8'($urandom));
      end else begin
        repeat ($urandom_range(4, 1))
          send_byte(8'($urandom));
      end
    end
  endtask

  // Drop valid, drain every expected angle, then let the block settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0)
      @(posedge clk);
    repeat (SETTLE)
      @(posedge clk);
  endtask

  task automatic write_config(input logic [2:0] joints, input logic [5:0] inv,
                              input logic [5:0] wide);
    cfg_we    <= 1'b1;
    cfg_index <= REG_JOINTS_IN_USE;
    cfg_wdata <= {3'b000, joints};
    @(posedge clk);
    cfg_index <= REG_INVERT_MASK;
    cfg_wdata <= inv;
    @(posedge clk);
    cfg_index <= REG_WIDE_MASK;
    cfg_wdata <= wide;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic run_phase(input logic [2:0] joints, input logic [5:0] inv,
                           input logic [5:0] wide, input int budget);
    wait_idle();
    write_config(joints, inv, wide);
    random_traffic(budget);
  endtask

  initial begin
    in_valid   <= 1'b0;
    in_rx_byte <= 8'h00;
    out_stall  <= 1'b0;
    cfg_we     <= 1'b0;
    cfg_index  <= REG_JOINTS_IN_USE;
    cfg_wdata  <= 6'd0;
    calm       <= 1'b0;
    rst_n      <= 1'b0;
    repeat (9)
      @(posedge clk);
    rst_n <= 1'b1;

    // stray byte, then a repeated start byte that must be re-checked as a header start;
    // joints carry zero, full scale, tiny, the upper end of both ranges and 380 under the reset settings
    send_byte(HDR1);
    send_byte(HDR0);
    send_frame({16'd380, 16'd3700, 16'd3100, 16'd1, 16'hFFFF, 16'd0});
    // leading three pulses zero: frame is dropped
    send_frame({16'h8000, 16'h7FFF, 16'd2000, 16'd0, 16'd0, 16'd0});
    random_traffic(20);

    // sweep the settings, extremes first
    run_phase(3'd7, 6'd63, 6'd0, 40);
    run_phase(3'd0, 6'd21, 6'd42, 25);
    run_phase(3'd1, 6'd63, 6'd63, 30);
    calm <= 1'b1;
    run_phase(3'd6, 6'd0, 6'd63, 50);
    calm <= 1'b0;
    run_phase(3'd6, 6'($urandom), 6'($urandom), 40);
    run_phase(3'($urandom_range(5, 2)), 6'($urandom), 6'($urandom), 30);

    wait_idle();
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
